// ----- hdl/pmw_sqi_pkg.sv -----
// ----------------------------------------------------------------------------
// pmw_sqi_pkg
// Shared types and constants for the pulse measurement window core.
// ----------------------------------------------------------------------------
package pmw_sqi_pkg;

	localparam int TIME_W          = 32;
	localparam int IR_W            = 18;
	localparam int TEMP_W          = 12;
	localparam int CNT_W           = 16;
	localparam int QUAL_W          = 24;
	localparam int EV_W            = 2;
	localparam int CFG_W           = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int SAMPLE_BITS_DEF = 18;
	localparam int STEP_W          = 5;
	localparam int FRAC_BITS       = 16;
	localparam int INT_BITS        = QUAL_W - FRAC_BITS;

	localparam logic [QUAL_W-1:0] QMAX = '1;

	localparam logic [TIME_W-1:0] WINDOW_RST = 32'd10000;
	localparam logic [TIME_W-1:0] IDLE_RST   = 32'd5000;
	localparam logic [CNT_W-1:0]  LIMIT_RST  = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

	localparam logic [EV_W-1:0] EV_WAITING = 2'd0;
	localparam logic [EV_W-1:0] EV_FOUND   = 2'd1;
	localparam logic [EV_W-1:0] EV_REMOVED = 2'd2;
	localparam logic [EV_W-1:0] EV_REPORT  = 2'd3;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_MEASURE = 3'd1,
		PH_PROCESS = 3'd2,
		PH_REPORT  = 3'd3,
		PH_IDLE    = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CS_IDLE = 2'd0,
		CS_MUL  = 2'd1,
		CS_CHK  = 2'd2,
		CS_DIV  = 2'd3
	} calc_t;

	typedef struct packed {
		logic [EV_W-1:0]          ev;
		logic [CNT_W-1:0]         cnt;
		logic signed [TEMP_W-1:0] temp;
		logic [QUAL_W-1:0]        qual;
	} res_t;

endpackage

// ----- hdl/pulse_measurement_window_sqi_core.sv -----
// ----------------------------------------------------------------------------
// pulse_measurement_window_sqi_core
// Finger-presence sequencer with windowed infrared statistics and a
// bit-serial quality index (max-min)*count/sum in unsigned Q8.16.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | now_ms, finger_present, ir_sample, temperature
//  out     | out_valid/out_stall| event_res, sample_count, reported_temperature,
//          |                    | quality_index
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  a processing tick runs an accept, 16 shift-add multiply steps, one range
//  check and 24 restoring divide steps; the divide is skipped when the index
//  is zero or saturates
//  results leave through an output register backed by one skid entry
//  arst_n clears the sequencer to waiting for finger and loads default config
//  in_stall is high while the multiply, range check or divide runs or the skid entry is occupied
// ----------------------------------------------------------------------------
module pulse_measurement_window_sqi_core #(
	parameter int SAMPLE_BITS = pmw_sqi_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pmw_sqi_pkg::TIME_W-1:0]        now_ms,
	input  logic                                  finger_present,
	input  logic [pmw_sqi_pkg::IR_W-1:0]          ir_sample,
	input  logic signed [pmw_sqi_pkg::TEMP_W-1:0] temperature,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pmw_sqi_pkg::EV_W-1:0]          event_res,
	output logic [pmw_sqi_pkg::CNT_W-1:0]         sample_count,
	output logic signed [pmw_sqi_pkg::TEMP_W-1:0] reported_temperature,
	output logic [pmw_sqi_pkg::QUAL_W-1:0]        quality_index,
	input  logic                                  cfg_we,
	input  logic [pmw_sqi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pmw_sqi_pkg::CFG_W-1:0]         cfg_data
);
	import pmw_sqi_pkg::*;

	localparam int IRU = (SAMPLE_BITS < IR_W) ? SAMPLE_BITS : IR_W;
	localparam int TW  = SAMPLE_BITS + CNT_W;
	localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(CNT_W - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUAL_W - 1);

	phase_t phase_q, phase_d;
	calc_t  cs_q, cs_d;
	logic [STEP_W-1:0]      step_q, step_d;
	logic [TIME_W-1:0]      win_q, win_d, idl_q, idl_d;
	logic [CNT_W-1:0]       lim_q, lim_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
	logic [TW-1:0]          tot_q, tot_d;
	logic [TIME_W-1:0]      wst_q, wst_d, ist_q, ist_d;
	logic signed [TEMP_W-1:0] htemp_q, htemp_d;
	logic [QUAL_W-1:0]      hqual_q, hqual_d;
	logic [TW-1:0]          prod_q, prod_d, mcand_q, mcand_d;
	logic [CNT_W-1:0]       mplier_q, mplier_d;
	logic [TW-1:0]          rem_q, rem_d;
	logic [QUAL_W-1:0]      divd_q, divd_d, quo_q, quo_d;
	logic                   ov_q, ov_d, sv_q, sv_d;
	res_t                   out_q, out_d, sk_q, sk_d;

	logic                   in_acc, out_free, r_vld;
	res_t                   r;
	logic [SAMPLE_BITS-1:0] ir_v;
	logic [TW:0]            trial;

	assign ir_v     = SAMPLE_BITS'(ir_sample[IRU-1:0]);
	assign in_stall = (cs_q != CS_IDLE) || sv_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !ov_q || !out_stall;
	assign trial    = {rem_q, divd_q[QUAL_W-1]};

	always_comb begin
		phase_d  = phase_q;
		cs_d     = cs_q;
		step_d   = step_q;
		win_d    = win_q;
		idl_d    = idl_q;
		lim_d    = lim_q;
		cnt_d    = cnt_q;
		min_d    = min_q;
		max_d    = max_q;
		tot_d    = tot_q;
		wst_d    = wst_q;
		ist_d    = ist_q;
		htemp_d  = htemp_q;
		hqual_d  = hqual_q;
		prod_d   = prod_q;
		mcand_d  = mcand_q;
		mplier_d = mplier_q;
		rem_d    = rem_q;
		divd_d   = divd_q;
		quo_d    = quo_q;
		r_vld    = 1'b0;
		r        = '0;

		if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW: win_d = cfg_data;
				REG_IDLE:   idl_d = cfg_data;
				REG_LIMIT:  lim_d = cfg_data[CNT_W-1:0];
				default:    ;
			endcase
		end

		if (in_acc) begin
			case (phase_q)
				PH_MEASURE: begin
					if (!finger_present) begin
						phase_d = PH_WAIT;
						r_vld   = 1'b1;
						r.ev    = EV_REMOVED;
					end else begin
						if (cnt_q < lim_q) begin
							if (cnt_q == '0) begin
								min_d = ir_v;
								max_d = ir_v;
							end else begin
								if (ir_v < min_q) min_d = ir_v;
								if (ir_v > max_q) max_d = ir_v;
							end
							tot_d = tot_q + TW'(ir_v);
							cnt_d = cnt_q + CNT_W'(1);
						end
						if ((now_ms - wst_q) >= win_q) phase_d = PH_PROCESS;
					end
				end
				PH_PROCESS: begin
					htemp_d  = temperature;
					cs_d     = CS_MUL;
					step_d   = '0;
					prod_d   = '0;
					mcand_d  = TW'(max_q - min_q);
					mplier_d = cnt_q;
				end
				PH_REPORT: begin
					ist_d   = now_ms;
					phase_d = PH_IDLE;
					r_vld   = 1'b1;
					r.ev    = EV_REPORT;
					r.cnt   = cnt_q;
					r.temp  = htemp_q;
					r.qual  = hqual_q;
				end
				PH_IDLE: begin
					if ((now_ms - ist_q) >= idl_q) begin
						phase_d = PH_WAIT;
						r_vld   = 1'b1;
						r.ev    = EV_WAITING;
					end
				end
				default: begin
					phase_d = PH_WAIT;
					if (finger_present) begin
						cnt_d   = '0;
						min_d   = '0;
						max_d   = '0;
						tot_d   = '0;
						wst_d   = now_ms;
						phase_d = PH_MEASURE;
						r_vld   = 1'b1;
						r.ev    = EV_FOUND;
					end
				end
			endcase
		end

		// serial multiply, range check, serial divide
		case (cs_q)
			CS_MUL: begin
				if (mplier_q[0]) prod_d = prod_q + mcand_q;
				mcand_d  = mcand_q << 1;
				mplier_d = mplier_q >> 1;
				step_d   = step_q + STEP_W'(1);
				if (step_q == MUL_LAST) cs_d = CS_CHK;
			end
			CS_CHK: begin
				if (cnt_q == '0 || tot_q == '0) begin
					hqual_d = '0;
					cs_d    = CS_IDLE;
					phase_d = PH_REPORT;
				end else if ({8'd0, prod_q} >= {tot_q, 8'd0}) begin
					hqual_d = QMAX;
					cs_d    = CS_IDLE;
					phase_d = PH_REPORT;
				end else begin
					rem_d  = TW'(prod_q[TW-1:INT_BITS]);
					divd_d = {prod_q[INT_BITS-1:0], FRAC_BITS'(0)};
					quo_d  = '0;
					step_d = '0;
					cs_d   = CS_DIV;
				end
			end
			CS_DIV: begin
				if (trial >= {1'b0, tot_q}) begin
					rem_d = TW'(trial - {1'b0, tot_q});
					quo_d = {quo_q[QUAL_W-2:0], 1'b1};
				end else begin
					rem_d = trial[TW-1:0];
					quo_d = {quo_q[QUAL_W-2:0], 1'b0};
				end
				divd_d = divd_q << 1;
				step_d = step_q + STEP_W'(1);
				if (step_q == DIV_LAST) begin
					hqual_d = quo_d;
					cs_d    = CS_IDLE;
					phase_d = PH_REPORT;
				end
			end
			default: ;
		endcase

		// output register with one skid entry
		ov_d  = ov_q;
		sv_d  = sv_q;
		out_d = out_q;
		sk_d  = sk_q;
		if (out_free) begin
			if (sv_q) begin
				out_d = sk_q;
				ov_d  = 1'b1;
				sv_d  = 1'b0;
			end else if (r_vld) begin
				out_d = r;
				ov_d  = 1'b1;
			end else begin
				ov_d = 1'b0;
			end
		end else if (r_vld) begin
			sk_d = r;
			sv_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			cs_q    <= CS_IDLE;
			step_q  <= '0;
			win_q   <= WINDOW_RST;
			idl_q   <= IDLE_RST;
			lim_q   <= LIMIT_RST;
			cnt_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			tot_q   <= '0;
			wst_q   <= '0;
			ist_q   <= '0;
			htemp_q <= '0;
			hqual_q <= '0;
			ov_q    <= 1'b0;
			sv_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cs_q    <= cs_d;
			step_q  <= step_d;
			win_q   <= win_d;
			idl_q   <= idl_d;
			lim_q   <= lim_d;
			cnt_q   <= cnt_d;
			min_q   <= min_d;
			max_q   <= max_d;
			tot_q   <= tot_d;
			wst_q   <= wst_d;
			ist_q   <= ist_d;
			htemp_q <= htemp_d;
			hqual_q <= hqual_d;
			ov_q    <= ov_d;
			sv_q    <= sv_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q   <= prod_d;
		mcand_q  <= mcand_d;
		mplier_q <= mplier_d;
		rem_q    <= rem_d;
		divd_q   <= divd_d;
		quo_q    <= quo_d;
		out_q    <= out_d;
		sk_q     <= sk_d;
	end

	assign out_valid            = ov_q;
	assign event_res            = out_q.ev;
	assign sample_count         = out_q.cnt;
	assign reported_temperature = out_q.temp;
	assign quality_index        = out_q.qual;

endmodule

// ----- sim/pulse_measurement_window_sqi_core_tb.sv -----
// ----------------------------------------------------------------------------
// pulse_measurement_window_sqi_core_tb
// Self-checking bench for the finger-presence sequencer and quality index.
// A scoreboard class tracks the sequencer and window statistics for every
// accepted tick and checks each result beat in order. Directed ticks cover
// the register extremes, timestamp wrap, window abort, zero sum and an empty
// window. Random sessions then run under several register settings and
// handshake idling patterns, with a receiver hold-off and a saturating window.
// ----------------------------------------------------------------------------
module pulse_measurement_window_sqi_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pmw_sqi_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;

	class window_scoreboard;
		logic [TIME_W-1:0]        window_ms;
		logic [TIME_W-1:0]        idle_ms;
		logic [CNT_W-1:0]         limit;
		phase_t                   phase;
		logic [CNT_W-1:0]         count;
		logic [IR_W-1:0]          ir_lo;
		logic [IR_W-1:0]          ir_hi;
		logic [33:0]              ir_sum;
		logic [TIME_W-1:0]        win_t0;
		logic [TIME_W-1:0]        idle_t0;
		logic signed [TEMP_W-1:0] held_temp;
		logic [QUAL_W-1:0]        held_q;
		res_t                     awaited[$];
		int ticks, results, reports, saturated, aborts, errors;

		function new();
			window_ms = WINDOW_RST;
			idle_ms   = IDLE_RST;
			limit     = LIMIT_RST;
			phase     = PH_WAIT;
			count     = '0;
			ir_lo     = '0;
			ir_hi     = '0;
			ir_sum    = '0;
			win_t0    = '0;
			idle_t0   = '0;
			held_temp = '0;
			held_q    = '0;
			ticks = 0; results = 0; reports = 0; saturated = 0; aborts = 0; errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
			REG_WINDOW: window_ms = d;
			REG_IDLE:   idle_ms = d;
			REG_LIMIT:  limit = d[CNT_W-1:0];
			default: ;
			endcase
		endfunction

		// (max-min)*count/sum in Q8.16, truncated, saturating
		function logic [QUAL_W-1:0] window_sqi();
			logic [63:0] hi, lo, num, tot, whole, rem, q;
			if (count == 0 || ir_sum == 0)
				return '0;
			hi  = 64'(ir_hi);
			lo  = 64'(ir_lo);
			tot = 64'(ir_sum);
			num = (hi - lo) * 64'(count);
			if (num >= tot * 256)
				return QMAX;
			whole = num / tot;
			rem   = num % tot;
			q = (whole << FRAC_BITS) + ((rem << FRAC_BITS) / tot);
			return (q > 64'(QMAX)) ? QMAX : q[QUAL_W-1:0];
		endfunction

		function void note_tick(logic [TIME_W-1:0] now, logic finger,
		                        logic [IR_W-1:0] ir, logic [TEMP_W-1:0] temp);
			res_t r;
			bit emit;
			r = '0;
			emit = 0;
			ticks++;
			case (phase)
			PH_MEASURE: begin
				if (!finger) begin
					phase = PH_WAIT;
					r.ev = EV_REMOVED;
					emit = 1;
					aborts++;
				end else begin
					if (count < limit) begin
						if (count == 0) begin
							ir_lo = ir;
							ir_hi = ir;
						end
						if (ir < ir_lo)
							ir_lo = ir;
						if (ir > ir_hi)
							ir_hi = ir;
						ir_sum += 34'(ir);
						count++;
					end
					if (now - win_t0 >= window_ms)
						phase = PH_PROCESS;
				end
			end
			PH_PROCESS: begin
				held_temp = temp;
				held_q = window_sqi();
				phase = PH_REPORT;
			end
			PH_REPORT: begin
				idle_t0 = now;
				phase = PH_IDLE;
				r.ev = EV_REPORT;
				r.cnt = count;
				r.temp = held_temp;
				r.qual = held_q;
				emit = 1;
				reports++;
				if (held_q == QMAX)
					saturated++;
			end
			PH_IDLE: begin
				if (now - idle_t0 >= idle_ms) begin
					phase = PH_WAIT;
					r.ev = EV_WAITING;
					emit = 1;
				end
			end
			default: begin
				phase = PH_WAIT;
				if (finger) begin
					count = '0;
					ir_lo = '0;
					ir_hi = '0;
					ir_sum = '0;
					win_t0 = now;
					phase = PH_MEASURE;
					r.ev = EV_FOUND;
					emit = 1;
				end
			end
			endcase
			if (emit)
				awaited.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			results++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result beat with nothing pending: ev %0d cnt %0d temp %0d sqi %06h",
					         got.ev, got.cnt, got.temp, got.qual);
				return;
			end
			want = awaited.pop_front();
			if (got.ev !== want.ev || got.cnt !== want.cnt || got.temp !== want.temp ||
			    got.qual !== want.qual) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: want ev %0d cnt %0d temp %0d sqi %06h, got ev %0d cnt %0d temp %0d sqi %06h",
					         want.ev, want.cnt, want.temp, want.qual,
					         got.ev, got.cnt, got.temp, got.qual);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [TIME_W-1:0]        now_ms;
	logic                     finger_present;
	logic [IR_W-1:0]          ir_sample;
	logic signed [TEMP_W-1:0] temperature;
	logic                     out_valid;
	logic                     out_stall;
	logic [EV_W-1:0]          event_res;
	logic [CNT_W-1:0]         sample_count;
	logic signed [TEMP_W-1:0] reported_temperature;
	logic [QUAL_W-1:0]        quality_index;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	window_scoreboard sb = new();
	logic [TIME_W-1:0] stamp;
	int snd_idle_pct;
	int rcv_stall_pct;
	int hold_request;

	pulse_measurement_window_sqi_core i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.now_ms               (now_ms),
		.finger_present       (finger_present),
		.ir_sample            (ir_sample),
		.temperature          (temperature),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.event_res            (event_res),
		.sample_count         (sample_count),
		.reported_temperature (reported_temperature),
		.quality_index        (quality_index),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// valid stays high across back-to-back beats; only gaps lower it
	task automatic offer_tick(logic [TIME_W-1:0] now, logic finger,
	                          logic [IR_W-1:0] ir, logic [TEMP_W-1:0] temp);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		now_ms         <= now;
		finger_present <= finger;
		ir_sample      <= ir;
		temperature    <= temp;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_tick(now, finger, ir, temp);
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed sessions; ignored waiting ticks are not counted
	task automatic sensor_ticks(int n);
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] step;
		logic              finger;
		logic [IR_W-1:0]   ir;
		logic [TEMP_W-1:0] temp;
		int done;
		done = 0;
		while (done < n) begin
			case (sb.phase)
			PH_WAIT:    finger = ($urandom_range(0, 99) < 85);
			PH_MEASURE: finger = ($urandom_range(0, 99) < 94);
			default:    finger = 1'($urandom_range(0, 1));
			endcase
			if (!(sb.phase == PH_WAIT && !finger))
				done++;
			span = (sb.phase == PH_IDLE) ? sb.idle_ms : sb.window_ms;
			if ($urandom_range(0, 99) < 3)
				step = $urandom;
			else
				step = $urandom_range(0, span / 3 + 1);
			stamp += step;
			case ($urandom_range(0, 4))
			0:       ir = IR_W'($urandom);
			1:       ir = $urandom_range(0, 1) ? 18'h3FFFF : 18'h0;
			default: ir = IR_W'(200000 + $urandom_range(0, 4000));
			endcase
			temp = TEMP_W'($urandom);
			offer_tick(stamp, finger, ir, temp);
		end
	endtask

	// one spike among 300 samples, the rest zero, pushes the index past Q8.16 range
	task automatic saturating_window();
		int k;
		while (sb.phase != PH_WAIT) begin
			stamp += sb.idle_ms;
			offer_tick(stamp, 1'b0, 18'h0, 12'h0);
		end
		stamp += 1;
		offer_tick(stamp, 1'b1, 18'h0, 12'h0);
		for (k = 0; k < 300; k++) begin
			stamp += 1;
			offer_tick(stamp, 1'b1, (k == 150) ? 18'h3FFFF : 18'h0, 12'h0);
		end
		offer_tick(stamp, 1'b1, 18'h0, 12'h5A5);
		offer_tick(stamp, 1'b1, 18'h0, 12'h0);
	endtask

	// result side: check accepted beats, stall at random or hold off on request
	initial begin
		res_t got;
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got.ev   = event_res;
				got.cnt  = sample_count;
				got.temp = reported_temperature;
				got.qual = quality_index;
				sb.check_result(got);
			end
			if (hold_left == 0 && hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			    (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [TIME_W-1:0] t0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		now_ms         <= '0;
		finger_present <= 1'b0;
		ir_sample      <= '0;
		temperature    <= '0;
		cfg_we         <= 1'b0;
		cfg_index      <= '0;
		cfg_data       <= '0;
		hold_request   = 0;
		snd_idle_pct   = 15;
		rcv_stall_pct  = 70;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest window, no idle, no samples, ignored register index
		write_reg(REG_WINDOW, 32'd1);
		write_reg(REG_IDLE, 32'd0);
		write_reg(REG_LIMIT, 32'h0001_0000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		offer_tick(32'd100, 1'b0, 18'h3FFFF, 12'h0);
		offer_tick(32'd100, 1'b1, 18'h0, 12'h0);
		offer_tick(32'd101, 1'b1, 18'h3FFFF, 12'h0);
		offer_tick(32'd102, 1'b0, 18'h0, 12'h800);
		offer_tick(32'd103, 1'b1, 18'h0, 12'h0);
		offer_tick(32'd103, 1'b0, 18'h0, 12'h0);

		// longest window and idle, timestamp wrap, abort, zero-sum window
		drain_and_settle();
		write_reg(REG_WINDOW, 32'hFFFF_FFFF);
		write_reg(REG_IDLE, 32'hFFFF_FFFF);
		write_reg(REG_LIMIT, 32'h0000_FFFF);
		t0 = 32'hFFFF_FFF0;
		offer_tick(t0, 1'b1, 18'h0, 12'h0);
		offer_tick(t0 + 1, 1'b1, 18'h0, 12'hFFF);
		offer_tick(t0 + 2, 1'b1, 18'h3FFFF, 12'h0);
		offer_tick(t0 + 3, 1'b1, 18'h1, 12'h0);
		offer_tick(t0 + 4, 1'b0, 18'h0, 12'h0);
		t0 = t0 + 5;
		offer_tick(t0, 1'b1, 18'h0, 12'h0);
		offer_tick(t0 + 5, 1'b1, 18'h0, 12'h0);
		offer_tick(t0 - 1, 1'b1, 18'h0, 12'h0);
		offer_tick(t0, 1'b1, 18'h0, 12'h7FF);
		t0 = 32'h8000_0000;
		offer_tick(t0, 1'b0, 18'h0, 12'h0);
		offer_tick(t0 + 32'hFFFF_FFFE, 1'b0, 18'h0, 12'h0);
		offer_tick(t0 + 32'hFFFF_FFFF, 1'b1, 18'h0, 12'h0);

		// slow sender side idle, busy receiver
		drain_and_settle();
		write_reg(REG_WINDOW, 32'd10000);
		write_reg(REG_IDLE, 32'd5000);
		write_reg(REG_LIMIT, 32'd4);
		stamp = $urandom;
		sensor_ticks(120);

		// receiver holds off while ticks keep coming, then a full drain
		drain_and_settle();
		write_reg(REG_WINDOW, 32'd1);
		write_reg(REG_IDLE, 32'd0);
		write_reg(REG_LIMIT, 32'd1);
		snd_idle_pct = 0;
		hold_request = HOLD_CYCLES;
		sensor_ticks(40);
		drain_and_settle();

		// roles swapped
		snd_idle_pct  = 70;
		rcv_stall_pct = 15;
		write_reg(REG_WINDOW, $urandom_range(1, 50));
		write_reg(REG_IDLE, $urandom_range(0, 20));
		write_reg(REG_LIMIT, 32'd65535);
		sensor_ticks(120);

		// back-to-back beats, saturating index then short windows
		drain_and_settle();
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		write_reg(REG_WINDOW, 32'd300);
		write_reg(REG_IDLE, 32'd0);
		saturating_window();
		drain_and_settle();
		write_reg(REG_WINDOW, 32'd2000);
		write_reg(REG_IDLE, 32'd3000);
		write_reg(REG_LIMIT, 32'd7);
		sensor_ticks(100);

		drain_and_settle();
		$display("%0d ticks accepted, %0d result beats checked, %0d reports, %0d saturated",
		         sb.ticks, sb.results, sb.reports, sb.saturated);
		$display("%0d windows aborted by finger removal", sb.aborts);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d errors, %0d results never arrived", sb.errors, sb.pending());
			$display("Verification failed");
		end
		$finish;
	end

endmodule
